// File: rtl/core/lcgja_pkg.sv
`default_nettype none

package lcgja_pkg;

   // field widths and the prime modulus 2^31-1
   localparam int unsigned VAL_W   = 31;
   localparam int unsigned CNT_W   = 31;
   localparam int unsigned PROD_W  = 2 * VAL_W;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [VAL_W-1:0] LCG_MOD       = 31'h7FFF_FFFF;
   localparam logic [VAL_W-1:0] MULT_RESET    = 31'd48271;
   localparam logic [VAL_W-1:0] INC_RESET     = 31'd0;
   localparam logic [VAL_W-1:0] VAL_ZERO      = '0;
   localparam logic [VAL_W-1:0] VAL_ONE       = 31'd1;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_MULTIPLIER = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_INCREMENT  = 1'b1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_GAP,
      ST_FIN,
      ST_OUT
   } state_type;

   // operations issued to the shared multiply unit
   typedef enum logic [2:0] {
      OP_RM,    // running multiplier times step multiplier
      OP_RA,    // running increment times step multiplier, plus step increment
      OP_SA,    // step increment times (step multiplier + 1)
      OP_SM,    // step multiplier squared
      OP_FIN    // running multiplier plus running increment
   } op_type;

   // a full-width input of all ones is congruent to zero
   function automatic logic [VAL_W-1:0] mod_fix(input logic [VAL_W-1:0] x);
      mod_fix = (x == LCG_MOD) ? VAL_ZERO : x;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/lcgja_mulmod.sv
`default_nettype none

module lcgja_mulmod (
   input  wire logic                      clock,
   input  wire logic                      load,
   input  wire logic [lcgja_pkg::VAL_W-1:0] op_a,
   input  wire logic [lcgja_pkg::VAL_W-1:0] op_b,
   input  wire logic [lcgja_pkg::VAL_W-1:0] addend,
   output logic      [lcgja_pkg::VAL_W-1:0] result
);
   import lcgja_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [VAL_W-1:0]  addend_ff;
   logic [VAL_W-1:0]  addend_in;
   logic [VAL_W+1:0]  sum3;
   logic [VAL_W:0]    fold;

   // product and addend captured on issue, held otherwise
   always_comb begin
      prod_in   = load ? (PROD_W'(op_a) * PROD_W'(op_b)) : prod_ff;
      addend_in = load ? addend : addend_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      addend_ff <= addend_in;
   end

   // 2^31 is 1 mod 2^31-1: add the halves and the addend, fold the carry,
   // then one conditional subtract
   always_comb begin
      sum3 = {2'b00, prod_ff[PROD_W-1:VAL_W]} + {2'b00, prod_ff[VAL_W-1:0]}
           + {2'b00, addend_ff};
      fold = {1'b0, sum3[VAL_W-1:0]} + {{(VAL_W-1){1'b0}}, sum3[VAL_W+1:VAL_W]};
      if (fold >= {1'b0, LCG_MOD}) begin
         result = VAL_W'(fold - {1'b0, LCG_MOD});
      end else begin
         result = fold[VAL_W-1:0];
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/lcg_jump_ahead.sv
// throughput: one item at a time, the 31x31 modular multiplier is shared by the updates
//   of each count bit (four for a set bit, two for a clear one) and by the final add
// reset: synchronous, returns to idle with multiplier 48271 and increment 0
`default_nettype none

module lcg_jump_ahead (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [lcgja_pkg::VAL_W-1:0]     req_seed_value,
   input  wire logic [lcgja_pkg::CNT_W-1:0]     req_skip_count,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [lcgja_pkg::VAL_W-1:0]     rsp_advanced_value,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [lcgja_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lcgja_pkg::VAL_W-1:0]     csr_data
);
   import lcgja_pkg::*;

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   op_type           wb_op_ff, wb_op_in;
   op_type           issue_op;
   logic             wb_valid_ff, wb_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic [VAL_W-1:0] mult_ff, mult_in;
   logic [VAL_W-1:0] inc_ff, inc_in;
   logic [VAL_W-1:0] run_mul_ff, run_mul_in;
   logic [VAL_W-1:0] run_add_ff, run_add_in;
   logic [VAL_W-1:0] step_mul_ff, step_mul_in;
   logic [VAL_W-1:0] step_add_ff, step_add_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             issue;
   logic [VAL_W-1:0] mm_a, mm_b, mm_add, mm_result;
   logic [VAL_W-1:0] step_mul_p1;

   // configuration registers, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      mult_in = mult_ff;
      inc_in  = inc_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_MULTIPLIER: mult_in = csr_data;
            REG_INCREMENT:  inc_in  = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff <= MULT_RESET;
         inc_ff  <= INC_RESET;
      end else begin
         mult_ff <= mult_in;
         inc_ff  <= inc_in;
      end
   end

   // (step multiplier + 1) mod 2^31-1
   assign step_mul_p1 = (step_mul_ff == LCG_MOD - VAL_ONE) ? VAL_ZERO : step_mul_ff + VAL_ONE;

   // operand selection for the shared unit
   always_comb begin
      issue_op = (state_ff == ST_FIN) ? OP_FIN : op_ff;
      unique case (issue_op)
         OP_RM: begin
            mm_a = run_mul_ff;  mm_b = step_mul_ff;  mm_add = VAL_ZERO;
         end
         OP_RA: begin
            mm_a = run_add_ff;  mm_b = step_mul_ff;  mm_add = step_add_ff;
         end
         OP_SA: begin
            mm_a = step_add_ff; mm_b = step_mul_p1;  mm_add = VAL_ZERO;
         end
         OP_SM: begin
            mm_a = step_mul_ff; mm_b = step_mul_ff;  mm_add = VAL_ZERO;
         end
         OP_FIN: begin
            mm_a = run_mul_ff;  mm_b = VAL_ONE;      mm_add = run_add_ff;
         end
         default: begin
            mm_a = VAL_ZERO;    mm_b = VAL_ZERO;     mm_add = VAL_ZERO;
         end
      endcase
   end

   assign issue = (state_ff == ST_RUN) || (state_ff == ST_FIN);

   lcgja_mulmod u_mulmod (
      .clock  (clock),
      .load   (issue),
      .op_a   (mm_a),
      .op_b   (mm_b),
      .addend (mm_add),
      .result (mm_result)
   );

   // sequencer: next state, write-back and result register
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      wb_op_in     = wb_op_ff;
      wb_valid_in  = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      run_mul_in   = run_mul_ff;
      run_add_in   = run_add_ff;
      step_mul_in  = step_mul_ff;
      step_add_in  = step_add_ff;
      count_in     = count_ff;

      // result leaves on its transfer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // write-back of the operation issued in the previous cycle
      if (wb_valid_ff) begin
         case (wb_op_ff)
            OP_RM:   run_mul_in  = mm_result;
            OP_RA:   run_add_in  = mm_result;
            OP_SA:   step_add_in = mm_result;
            OP_SM:   step_mul_in = mm_result;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               run_mul_in  = mod_fix(req_seed_value);
               run_add_in  = VAL_ZERO;
               step_mul_in = mod_fix(mult_ff);
               step_add_in = mod_fix(inc_ff);
               count_in    = req_skip_count;
               op_in       = req_skip_count[0] ? OP_RM : OP_SA;
               state_in    = (req_skip_count == '0) ? ST_FIN : ST_RUN;
            end
         end
         ST_RUN: begin
            wb_valid_in = 1'b1;
            wb_op_in    = op_ff;
            case (op_ff)
               OP_RM: op_in = OP_RA;
               OP_RA: op_in = OP_SA;
               OP_SA: op_in = OP_SM;
               default: begin
                  count_in = count_ff >> 1;
                  state_in = ST_GAP;
               end
            endcase
         end
         ST_GAP: begin
            // step multiplier is written back here, so nothing issues
            op_in    = count_ff[0] ? OP_RM : OP_SA;
            state_in = (count_ff == '0) ? ST_FIN : ST_RUN;
         end
         ST_FIN: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = mm_result;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_RM;
         wb_op_ff     <= OP_RM;
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         wb_op_ff     <= wb_op_in;
         wb_valid_ff  <= wb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working values and result payload
   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      run_mul_ff   <= run_mul_in;
      run_add_ff   <= run_add_in;
      step_mul_ff  <= step_mul_in;
      step_add_ff  <= step_add_in;
      count_ff     <= count_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_advanced_value = rsp_value_ff;

`ifndef ASSERT_OFF
   // write-back only follows an issue inside the bit loop
   assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> (state_ff == ST_RUN || state_ff == ST_GAP))
      else $error("write-back outside the bit loop");

   // working values stay reduced while an item is in flight
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (run_mul_ff < LCG_MOD && run_add_ff < LCG_MOD
                                 && step_mul_ff < LCG_MOD && step_add_ff < LCG_MOD))
      else $error("working value not reduced");

   // an accepted item makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block not busy after transfer");

   // a result only appears from the output step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OUT))
      else $error("result raised outside output step");
`endif

endmodule

`default_nettype wire

// File: tb/sv/lcg_jump_checker.sv
`timescale 1ns / 100ps

module lcg_jump_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_stall,
   input  wire logic [lcgja_pkg::VAL_W-1:0]     req_seed_value,
   input  wire logic [lcgja_pkg::CNT_W-1:0]     req_skip_count,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   input  wire logic [lcgja_pkg::VAL_W-1:0]     rsp_advanced_value,
   input  wire logic                            csr_valid,
   input  wire logic                            csr_ready,
   input  wire logic [lcgja_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lcgja_pkg::VAL_W-1:0]     csr_data,
   output int                                   fail_count,
   output int                                   pending
);
   import lcgja_pkg::*;

   localparam logic [63:0] PRIME = {33'd0, LCG_MOD};

   logic [VAL_W-1:0] mult_reg = MULT_RESET;
   logic [VAL_W-1:0] inc_reg  = INC_RESET;
   logic [VAL_W-1:0] expected_states [$];
   int               mismatches  = 0;
   int               outstanding = 0;

   assign fail_count = mismatches;
   assign pending    = outstanding;

   // product of two residues, reduced modulo the prime
   function automatic logic [63:0] mod_product(input logic [63:0] p, input logic [63:0] q);
      return (p * q) % PRIME;
   endfunction

   // state after count generator steps, by doubling the step over the count bits
   function automatic logic [VAL_W-1:0] jump_state(input logic [VAL_W-1:0] seed,
                                                   input logic [CNT_W-1:0] count,
                                                   input logic [VAL_W-1:0] mult,
                                                   input logic [VAL_W-1:0] inc);
      logic [63:0]      run_mul;
      logic [63:0]      run_add;
      logic [63:0]      step_mul;
      logic [63:0]      step_add;
      logic [63:0]      sum;
      logic [VAL_W-1:0] state;
      run_mul  = {33'd0, seed} % PRIME;
      run_add  = '0;
      step_mul = {33'd0, mult} % PRIME;
      step_add = {33'd0, inc} % PRIME;
      for (int k = 0; k < CNT_W; k++) begin
         if (count[k]) begin
            run_mul = mod_product(run_mul, step_mul);
            run_add = (mod_product(run_add, step_mul) + step_add) % PRIME;
         end
         // the increment doubles with the old multiplier
         step_add = mod_product(step_add, (step_mul + 64'd1) % PRIME);
         step_mul = mod_product(step_mul, step_mul);
      end
      sum   = (run_mul + run_add) % PRIME;
      state = sum[VAL_W-1:0];
      return state;
   endfunction

   task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                  input logic [VAL_W-1:0] want);
      $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
      mismatches = mismatches + 1;
   endtask

   // follow register writes, predict on each input transfer, compare on each result transfer
   always @(posedge clock) begin : watch
      logic [VAL_W-1:0] want;
      if (reset) begin
         expected_states.delete();
         mult_reg    <= MULT_RESET;
         inc_reg     <= INC_RESET;
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MULTIPLIER: mult_reg <= csr_data;
               REG_INCREMENT:  inc_reg  <= csr_data;
            endcase
         end
         if (req_valid && !req_stall)
            expected_states.push_back(jump_state(req_seed_value, req_skip_count,
                                                 mult_reg, inc_reg));
         if (rsp_valid && !rsp_stall) begin
            if (expected_states.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_advanced_value, VAL_ZERO);
            end else begin
               want = expected_states.pop_front();
               if (rsp_advanced_value !== want)
                  report_mismatch("advanced_value", rsp_advanced_value, want);
            end
         end
         outstanding <= expected_states.size();
      end
   end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
   import lcgja_pkg::*;

   localparam logic [VAL_W-1:0] TOP_RESIDUE = LCG_MOD - VAL_ONE;

   logic                 clock;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic [VAL_W-1:0]     req_seed_value = '0;
   logic [CNT_W-1:0]     req_skip_count = '0;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   logic [VAL_W-1:0]     rsp_advanced_value;
   logic                 csr_valid      = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index      = REG_MULTIPLIER;
   logic [VAL_W-1:0]     csr_data       = '0;
   logic                 calm           = 1'b0;
   int                   fail_count;
   int                   pending;

   lcg_jump_ahead dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_seed_value     (req_seed_value),
      .req_skip_count     (req_skip_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_advanced_value (rsp_advanced_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   lcg_jump_checker check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_seed_value     (req_seed_value),
      .req_skip_count     (req_skip_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_advanced_value (rsp_advanced_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // result side backpressure, switched off during the calm stretch
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= !calm && ($urandom_range(99) < 9);
   end

   // one input transfer, with random idle cycles ahead of it; valid is left high
   task automatic send_item(input logic [VAL_W-1:0] seed, input logic [CNT_W-1:0] count);
      while (!calm && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_seed_value <= seed;
      req_skip_count <= count;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid and wait until every predicted state has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // register write transfer; valid is left high for the caller to drop
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [VAL_W-1:0] mult, input logic [VAL_W-1:0] inc);
      wait_idle();
      csr_write(REG_MULTIPLIER, mult);
      csr_write(REG_INCREMENT, inc);
      csr_valid <= 1'b0;
   endtask

   // register values, biased towards the edges of the range
   function automatic logic [VAL_W-1:0] pick_reg_value();
      case ($urandom_range(5))
         0:       return VAL_ZERO;
         1:       return VAL_ONE;
         2:       return TOP_RESIDUE;
         3:       return LCG_MOD;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   function automatic logic [VAL_W-1:0] pick_seed();
      case ($urandom_range(15))
         0:       return VAL_ZERO;
         1:       return TOP_RESIDUE;
         2:       return LCG_MOD;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   // mostly short counts to keep the run quick, a quarter full width
   function automatic logic [CNT_W-1:0] pick_count();
      logic [31:0] mask;
      mask = (32'h1 << $urandom_range(1, 10)) - 32'h1;
      if ($urandom_range(3) == 0)
         return CNT_W'($urandom);
      return CNT_W'($urandom & mask);
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset register values: zero and unit counts, seed extremes, top count bit
      send_item(VAL_ONE, 31'd1);
      send_item(VAL_ZERO, 31'd0);
      send_item(TOP_RESIDUE, 31'd0);
      send_item(LCG_MOD, 31'd0);
      send_item(LCG_MOD, 31'd5);
      send_item(31'd12345, 31'h7FFF_FFFF);
      send_item(TOP_RESIDUE, 31'h4000_0000);
      send_item(31'd7, 31'h5555_5555);
      send_item(31'h2AAA_AAAA, 31'd2);

      // zero multiplier with the largest increment
      configure(VAL_ZERO, TOP_RESIDUE);
      send_item(31'd5, 31'd1);
      send_item(31'd5, 31'd3);
      send_item(31'd9, 31'h7FFF_FFFF);

      // all-ones registers act as zero
      configure(LCG_MOD, LCG_MOD);
      send_item(31'd123, 31'd1);
      send_item(31'd123, 31'd0);
      send_item(LCG_MOD, 31'h7FFF_FFFF);

      // unit multiplier and increment: plain counting
      configure(VAL_ONE, VAL_ONE);
      send_item(VAL_ZERO, 31'd1000);
      send_item(TOP_RESIDUE, 31'h7FFF_FFFF);

      // multiplier of minus one
      configure(TOP_RESIDUE, TOP_RESIDUE);
      send_item(31'd3, 31'd1);
      send_item(31'd3, 31'd2);
      send_item(31'h2AAA_AAAA, 31'h2AAA_AAAA);

      // random phases, each under its own register setting, one with no idling
      for (int p = 0; p < 9; p++) begin
         case (p)
            0:       configure(TOP_RESIDUE, TOP_RESIDUE);
            1:       configure(VAL_ONE, VAL_ZERO);
            2:       configure(MULT_RESET, VAL_W'($urandom));
            default: configure(pick_reg_value(), pick_reg_value());
         endcase
         calm <= (p == 4);
         for (int n = 0; n < 100; n++)
            send_item(pick_seed(), pick_count());
      end

      wait_idle();
      repeat (160) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: files.f
rtl/core/lcgja_pkg.sv
rtl/core/lcgja_mulmod.sv
rtl/core/lcg_jump_ahead.sv
tb/sv/lcg_jump_checker.sv
tb/sv/tb.sv
